// ===== rtl/core/chfi_pkg.sv =====
// ----------------------------------------------------------------------------
// chfi_pkg
// shared widths, defaults, op codes, controller states and the bucket hash
// ----------------------------------------------------------------------------
package chfi_pkg;

   localparam int KEY_W           = 16;
   localparam int ROW_IDX_W       = 11;
   localparam int HASH_W          = 18;
   localparam int DEF_BUCKET_BITS = 10;
   localparam int DEF_ROWS        = 2048;

   localparam logic OP_FIND  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [HASH_W-1:0] HMUL_A = HASH_W'(31);
   localparam logic [HASH_W-1:0] HMUL_B = HASH_W'(7);
   localparam logic [HASH_W-1:0] HMUL_C = HASH_W'(13);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_HEAD,
      ST_WALK,
      ST_DONE
   } state_type;

   // (k>>4)*31 + (k>>3)*7 + (k>>5)*7 + (k>>6)*13, before masking
   function automatic logic [HASH_W-1:0] bucket_hash(input logic [KEY_W-1:0] k);
      logic [HASH_W-1:0] t3;
      logic [HASH_W-1:0] t4;
      logic [HASH_W-1:0] t5;
      logic [HASH_W-1:0] t6;
      t3 = HASH_W'(k[KEY_W-1:3]);
      t4 = HASH_W'(k[KEY_W-1:4]);
      t5 = HASH_W'(k[KEY_W-1:5]);
      t6 = HASH_W'(k[KEY_W-1:6]);
      return t4 * HMUL_A + t3 * HMUL_B + t5 * HMUL_B + t6 * HMUL_C;
   endfunction

endpackage

// ===== rtl/core/chfi_ram.sv =====
// ----------------------------------------------------------------------------
// chfi_ram
// simple dual port ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module chfi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/chained_hash_find_or_insert.sv =====
// ----------------------------------------------------------------------------
// chained_hash_find_or_insert
// find-or-insert hash table with chained rows, keyed by a 16-bit tile index
// ----------------------------------------------------------------------------
// a request transaction carries op and key. op find looks the key up in its
// bucket chain, newest row first; a hit returns the row with found set, a miss
// appends a new row and returns its index, or raises table_full when every
// row is taken. op clear empties the table by zeroing the row count: a
// bucket head only counts when it points below the row count at a row that
// was written for that same bucket.
// sequence: a find reads the bucket head, then walks the chain with one row
// memory read per cycle (at least one even for an empty bucket), and raises
// rsp_valid once the response register is free; a clear goes straight to
// the response stage. req_ready is high only while the controller is idle,
// so a new request is taken only after the previous result is registered.
// if the receiver stalls with a result still held, the finished result waits
// in the controller and no further request is taken.
// after reset a clearing pass writes every bucket head to row 0 with
// req_ready low; reset also clears the row count, the controller and the
// response valid.
// ----------------------------------------------------------------------------
module chained_hash_find_or_insert
   import chfi_pkg::*;
#(
   parameter int BUCKET_BITS = DEF_BUCKET_BITS,
   parameter int ROWS        = DEF_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [KEY_W-1:0]     req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ROW_IDX_W-1:0] rsp_row_index,
   output logic                 rsp_found,
   output logic                 rsp_table_full
);

   localparam int ROW_W   = $clog2(ROWS);
   localparam int CNT_W   = $clog2(ROWS + 1);
   localparam int LINK_W  = ROW_W + 1;
   localparam int ROWMEM_W = BUCKET_BITS + LINK_W + KEY_W;
   localparam int NBUCKETS = 2 ** BUCKET_BITS;

   state_type state_ff, state_in;

   logic [BUCKET_BITS-1:0] init_ff, init_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [BUCKET_BITS-1:0] bucket_ff, bucket_in;
   logic [ROW_W-1:0]       head_ff, head_in;
   logic [ROW_W-1:0]       cur_ff, cur_in;
   logic                   first_ff, first_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ROW_W-1:0]       res_row_ff, res_row_in;
   logic                   res_found_ff, res_found_in;
   logic                   res_full_ff, res_full_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]       rsp_row_ff, rsp_row_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic                   rsp_full_ff, rsp_full_in;

   logic                   bkt_wr_en;
   logic [BUCKET_BITS-1:0] bkt_wr_addr;
   logic [ROW_W-1:0]       bkt_wr_data;
   logic                   bkt_rd_en;
   logic [BUCKET_BITS-1:0] bkt_rd_addr;
   logic [ROW_W-1:0]       bkt_rd_data;

   logic                   row_wr_en;
   logic [ROW_W-1:0]       row_wr_addr;
   logic [ROWMEM_W-1:0]    row_wr_data;
   logic                   row_rd_en;
   logic [ROW_W-1:0]       row_rd_addr;
   logic [ROWMEM_W-1:0]    row_rd_data;

   logic                   accept;
   logic                   out_free;
   logic [HASH_W-1:0]      hash;
   logic [KEY_W-1:0]       rd_key;
   logic [LINK_W-1:0]      rd_link;
   logic [BUCKET_BITS-1:0] rd_bucket;
   logic                   row_ok;
   logic                   hit;
   logic                   more;
   logic                   used;
   logic                   full;
   logic [LINK_W-1:0]      new_link;
   logic [ROW_W+ROW_IDX_W-1:0] row_wide;

   chfi_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NBUCKETS)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_wr_en),
      .wr_addr (bkt_wr_addr),
      .wr_data (bkt_wr_data),
      .rd_en   (bkt_rd_en),
      .rd_addr (bkt_rd_addr),
      .rd_data (bkt_rd_data)
   );

   chfi_ram #(
      .WIDTH (ROWMEM_W),
      .DEPTH (ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hash     = bucket_hash(req_key);

   // row entry: bucket, link (previous row plus one), key
   assign rd_key    = row_rd_data[KEY_W-1:0];
   assign rd_link   = row_rd_data[KEY_W +: LINK_W];
   assign rd_bucket = row_rd_data[KEY_W+LINK_W +: BUCKET_BITS];

   assign row_ok   = (CNT_W'(cur_ff) < count_ff) && (rd_bucket == bucket_ff);
   assign hit      = row_ok && (rd_key == key_ff);
   assign more     = row_ok && !hit && (rd_link != LINK_W'(0));
   assign used     = row_ok || !first_ff;
   assign full     = (count_ff == CNT_W'(ROWS));
   assign new_link = used ? (LINK_W'(head_ff) + LINK_W'(1)) : LINK_W'(0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (&init_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_op == OP_CLEAR) ? ST_DONE : ST_HEAD;
            end
         end
         ST_HEAD: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!more) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      init_in      = init_ff;
      key_in       = key_ff;
      bucket_in    = bucket_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      res_row_in   = res_row_ff;
      res_found_in = res_found_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      bkt_rd_en    = 1'b0;
      bkt_rd_addr  = hash[BUCKET_BITS-1:0];
      bkt_wr_en    = 1'b0;
      bkt_wr_addr  = bucket_ff;
      bkt_wr_data  = count_ff[ROW_W-1:0];
      row_rd_en    = 1'b0;
      row_rd_addr  = ROW_W'(rd_link - LINK_W'(1));
      row_wr_en    = 1'b0;
      row_wr_addr  = count_ff[ROW_W-1:0];
      row_wr_data  = {bucket_ff, new_link, key_ff};
      case (state_ff)
         ST_INIT: begin
            // clearing pass over the bucket heads
            bkt_wr_en   = 1'b1;
            bkt_wr_addr = init_ff;
            bkt_wr_data = '0;
            init_in     = init_ff + BUCKET_BITS'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               key_in    = req_key;
               bucket_in = hash[BUCKET_BITS-1:0];
               if (req_op == OP_CLEAR) begin
                  count_in     = '0;
                  res_row_in   = '0;
                  res_found_in = 1'b0;
                  res_full_in  = 1'b0;
               end else begin
                  bkt_rd_en = 1'b1;
               end
            end
         end
         ST_HEAD: begin
            head_in     = bkt_rd_data;
            cur_in      = bkt_rd_data;
            first_in    = 1'b1;
            row_rd_en   = 1'b1;
            row_rd_addr = bkt_rd_data;
         end
         ST_WALK: begin
            if (hit) begin
               res_row_in   = cur_ff;
               res_found_in = 1'b1;
               res_full_in  = 1'b0;
            end else if (more) begin
               row_rd_en = 1'b1;
               cur_in    = row_rd_addr;
               first_in  = 1'b0;
            end else if (full) begin
               res_row_in   = '0;
               res_found_in = 1'b0;
               res_full_in  = 1'b1;
            end else begin
               row_wr_en    = 1'b1;
               bkt_wr_en    = 1'b1;
               count_in     = count_ff + CNT_W'(1);
               res_row_in   = count_ff[ROW_W-1:0];
               res_found_in = 1'b0;
               res_full_in  = 1'b0;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = res_row_ff;
               rsp_found_in = res_found_ff;
               rsp_full_in  = res_full_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      bucket_ff    <= bucket_in;
      head_ff      <= head_in;
      cur_ff       <= cur_in;
      first_ff     <= first_in;
      res_row_ff   <= res_row_in;
      res_found_ff <= res_found_in;
      res_full_ff  <= res_full_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
   end

   // row number masked to the response width
   assign row_wide       = {{ROW_IDX_W{1'b0}}, rsp_row_ff};
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_index  = row_wide[ROW_IDX_W-1:0];
   assign rsp_found      = rsp_found_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for chained_hash_find_or_insert: a scoreboard keeps its
// own copy of the chained table, predicts each response from every accepted
// request transaction and compares responses in order. stimulus covers
// directed corner keys, a full table fill with hits and misses while full,
// and a short random mix of colliding keys, repeats and occasional clears,
// with random idling on both sides and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_top
   import chfi_pkg::*;
();

   localparam int N_BUCKETS  = 1 << DEF_BUCKET_BITS;
   localparam int TABLE_ROWS = DEF_ROWS;

   typedef struct packed {
      logic [ROW_IDX_W-1:0] row_index;
      logic                 found;
      logic                 table_full;
   } lookup_result_type;

   class tile_table_scoreboard_type;
      bit [ROW_IDX_W-1:0] head_row [N_BUCKETS];
      bit                 bucket_live [N_BUCKETS];
      bit [KEY_W-1:0]     row_tile [TABLE_ROWS];
      bit [11:0]          row_prev [TABLE_ROWS];
      int unsigned        rows_in_use;
      lookup_result_type  expected_lookups [$];
      int                 error_count;

      function new();
         rows_in_use = 0;
         error_count = 0;
         foreach (bucket_live[i]) bucket_live[i] = 1'b0;
      endfunction

      static function int unsigned bucket_for(logic [KEY_W-1:0] key);
         int unsigned k;
         int unsigned h;
         k = key;
         h = (k >> 4) * 31 + (k >> 3) * 7 + (k >> 5) * 7 + (k >> 6) * 13;
         return h % N_BUCKETS;
      endfunction

      function void accept_request(logic op, logic [KEY_W-1:0] key);
         lookup_result_type res;
         int unsigned       b;
         int unsigned       cur;
         int unsigned       steps;
         bit                hit;
         res = '0;
         hit = 1'b0;
         if (op == OP_CLEAR) begin
            foreach (bucket_live[i]) bucket_live[i] = 1'b0;
            rows_in_use = 0;
            expected_lookups = {expected_lookups, res};
            return;
         end
         b = bucket_for(key);
         if (bucket_live[b]) begin
            cur = head_row[b];
            for (steps = 0; steps < TABLE_ROWS && !hit; steps++) begin
               if (cur >= rows_in_use) break;
               if (row_tile[cur] == key) begin
                  hit = 1'b1;
                  res.row_index = cur[ROW_IDX_W-1:0];
                  res.found = 1'b1;
               end else if (row_prev[cur] == 12'd0) begin
                  break;
               end else begin
                  cur = row_prev[cur] - 1;
               end
            end
         end
         if (!hit) begin
            if (rows_in_use >= TABLE_ROWS) begin
               res.table_full = 1'b1;
            end else begin
               row_tile[rows_in_use] = key;
               row_prev[rows_in_use] = bucket_live[b] ? 12'(head_row[b]) + 12'd1 : 12'd0;
               head_row[b] = rows_in_use[ROW_IDX_W-1:0];
               bucket_live[b] = 1'b1;
               res.row_index = rows_in_use[ROW_IDX_W-1:0];
               rows_in_use++;
            end
         end
         expected_lookups = {expected_lookups, res};
      endfunction

      function void compare_response(logic [ROW_IDX_W-1:0] row_index, logic found,
                                     logic table_full);
         lookup_result_type want;
         if (expected_lookups.size() == 0) begin
            if (error_count < 40)
               $display("%0t: unexpected response row_index %0d found %0b table_full %0b",
                        $time, row_index, found, table_full);
            error_count++;
            return;
         end
         want = expected_lookups.pop_front();
         if (want.row_index !== row_index) begin
            if (error_count < 40)
               $display("%0t: row_index expected %0d actual %0d",
                        $time, want.row_index, row_index);
            error_count++;
         end
         if (want.found !== found) begin
            if (error_count < 40)
               $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            error_count++;
         end
         if (want.table_full !== table_full) begin
            if (error_count < 40)
               $display("%0t: table_full expected %0b actual %0b",
                        $time, want.table_full, table_full);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_lookups.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_op = OP_FIND;
   logic [KEY_W-1:0]     req_key = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ROW_IDX_W-1:0] rsp_row_index;
   logic                 rsp_found;
   logic                 rsp_table_full;

   tile_table_scoreboard_type sb;
   int                        sent_count = 0;
   int                        rsp_count = 0;

   chained_hash_find_or_insert #(
      .BUCKET_BITS (DEF_BUCKET_BITS),
      .ROWS        (DEF_ROWS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_index  (rsp_row_index),
      .rsp_found      (rsp_found),
      .rsp_table_full (rsp_table_full)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic op, input logic [KEY_W-1:0] key);
      int gap;
      gap = (sent_count % 256 < 48) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op    <= op;
      req_key   <= key;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.accept_request(op, key);
      sent_count++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.compare_response(rsp_row_index, rsp_found, rsp_table_full);
         rsp_count++;
      end
   end

   initial begin : response_side
      int  round;
      int  stall;
      bit  held_off;
      round = 0;
      held_off = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!held_off && rsp_count >= 300) begin
            // long hold-off so the block backs up and stalls its input
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         round++;
         if (round % 6 == 0) begin
            rsp_ready <= 1'b1;
            repeat (120) @(negedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   initial begin : timeout
      #(30_000_000);
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [KEY_W-1:0] alias_key;
      logic [KEY_W-1:0] k;
      logic [KEY_W-1:0] hot_base [16];
      logic [KEY_W-1:0] recent [$];
      logic             op;
      int unsigned      probe;
      int unsigned      fill_base;
      int               i;
      int               pick;

      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // a key in the same bucket as 0x1230 through the mask, not the shift
      for (probe = 8; probe < 65536; probe += 8)
         if (tile_table_scoreboard_type::bucket_for(16'(probe)) ==
             tile_table_scoreboard_type::bucket_for(16'h1230) &&
             (probe >> 3) != (16'h1230 >> 3))
            break;
      alias_key = 16'(probe);

      // directed: extremes, chains in one bucket, alias collision, clears
      send_request(OP_FIND, 16'h0000);
      send_request(OP_FIND, 16'h0000);
      send_request(OP_FIND, 16'hFFFF);
      send_request(OP_FIND, 16'hFFFF);
      send_request(OP_FIND, 16'h0001);
      send_request(OP_FIND, 16'h0007);
      send_request(OP_FIND, 16'h0000);
      send_request(OP_FIND, 16'h0001);
      send_request(OP_FIND, 16'h1230);
      send_request(OP_FIND, alias_key);
      send_request(OP_FIND, 16'h1230);
      send_request(OP_FIND, alias_key);
      send_request(OP_FIND, 16'hAAAA);
      send_request(OP_FIND, 16'h5555);
      send_request(OP_CLEAR, 16'hFFFF);
      send_request(OP_FIND, 16'h0007);
      send_request(OP_FIND, 16'h0000);
      send_request(OP_FIND, 16'hFFFF);
      send_request(OP_CLEAR, 16'h0000);
      send_request(OP_CLEAR, 16'h5555);
      send_request(OP_FIND, 16'hAAAA);

      // fill every row with distinct keys, then hits and misses while full
      fill_base = $urandom_range(0, 65535);
      send_request(OP_CLEAR, 16'($urandom));
      for (i = 0; i < TABLE_ROWS; i++) begin
         send_request(OP_FIND, 16'(fill_base + i * 29));
         if (i % 256 == 255)
            send_request(OP_FIND, 16'(fill_base + $urandom_range(0, i) * 29));
      end
      for (i = 0; i < 20; i++) begin
         if (i % 3 == 0)
            k = 16'(fill_base + $urandom_range(TABLE_ROWS, 4000) * 29);
         else
            k = 16'(fill_base + $urandom_range(0, TABLE_ROWS - 1) * 29);
         send_request(OP_FIND, k);
      end
      send_request(OP_FIND, 16'(fill_base + (TABLE_ROWS - 1) * 29));
      send_request(OP_FIND, 16'(fill_base));
      send_request(OP_CLEAR, 16'($urandom));

      // random mix: colliding hot keys, repeats, extremes, rare clears
      hot_base[0] = 16'h0000;
      hot_base[1] = 16'hFFF8;
      for (i = 2; i < 16; i++) hot_base[i] = 16'($urandom_range(0, 8191) << 3);
      for (i = 0; i < 50; i++) begin
         pick = $urandom_range(0, 999);
         op = OP_FIND;
         if (pick < 8) begin
            op = OP_CLEAR;
            k = 16'($urandom);
         end else if (pick < 500) begin
            k = hot_base[$urandom_range(0, 15)] | 16'($urandom_range(0, 7));
         end else if (pick < 750 && recent.size() > 0) begin
            k = recent[$urandom_range(0, recent.size() - 1)];
         end else if (pick < 770) begin
            k = (pick % 2) ? 16'hFFFF - 16'($urandom_range(0, 15)) : 16'($urandom_range(0, 15));
         end else begin
            k = 16'($urandom);
         end
         send_request(op, k);
         recent = {recent, k};
         if (recent.size() > 64) void'(recent.pop_front());
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== chained_hash_find_or_insert.f =====
rtl/core/chfi_pkg.sv
rtl/core/chfi_ram.sv
rtl/core/chained_hash_find_or_insert.sv
test/tb_top.sv
